[rtl/core/tse_pkg.sv]
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants for the table scan engine
// Memory geometry, form byte fields, status codes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tse_pkg;

   // story memory geometry
   localparam int MEM_BYTES = 65536;
   localparam int MEM_AW    = $clog2(MEM_BYTES);

   // scan address accumulator: a memory address plus a carry bit for overrun
   localparam int SCAN_AW = 17;
   localparam logic [SCAN_AW-1:0] MEM_LIMIT = SCAN_AW'(MEM_BYTES);

   // form byte fields
   localparam logic [7:0] FORM_DEFAULT = 8'h82;
   localparam logic [7:0] FORM_WORDS   = 8'h80;
   localparam logic [7:0] FORM_STRIDE  = 8'h7f;

   // oldest machine version that supports scans
   localparam logic [3:0] MIN_VERSION   = 4'd4;
   localparam logic [3:0] VERSION_RESET = 4'd5;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_STORY_BYTES   = 1'b0,
      CSR_STORY_VERSION = 1'b1
   } csr_index_type;

   // request function codes
   typedef enum logic [0:0] {
      FUNC_WRITE = 1'b0,
      FUNC_SCAN  = 1'b1
   } func_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_STRIDE  = 2'd1,
      ST_RANGE   = 2'd2,
      ST_VERSION = 2'd3
   } status_type;

   // kind of result the controller asks for
   typedef enum logic [2:0] {
      RK_ACK,
      RK_VERSION,
      RK_STRIDE,
      RK_RANGE,
      RK_HIT,
      RK_MISS
   } rsp_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         write;
      logic         load;
      logic         issue;
      logic         respond;
      rsp_kind_type kind;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic ver_old;
      logic stride_zero;
      logic remain_zero;
      logic tok_vld;
      logic tok_err;
      logic tok_hit;
   } sts_type;

endpackage

[rtl/core/tse_ram.sv]
// ----------------------------------------------------------------------------
// tse_ram: generic single-write, dual-read RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module tse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

[rtl/core/tse_datapath.sv]
// ----------------------------------------------------------------------------
// tse_datapath: story memory, scan walker and result registers
// Holds the configuration registers, walks table entries one per cycle
// via the registered RAM read and the key compare, registers each result.
// ----------------------------------------------------------------------------
module tse_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  tse_pkg::ctl_type       ctl,
   output tse_pkg::sts_type       sts,
   input  logic [15:0]            req_mem_addr,
   input  logic [7:0]             req_mem_byte,
   input  logic [15:0]            req_search_key,
   input  logic [15:0]            req_table_addr,
   input  logic [15:0]            req_entry_count,
   input  logic                   req_form_present,
   input  logic [7:0]             req_form_byte,
   input  logic                   csr_write,
   input  logic [0:0]             csr_index,
   input  logic [16:0]            csr_wdata,
   output logic                   rsp_valid,
   output logic [15:0]            rsp_match_addr,
   output logic                   rsp_matched,
   output logic [1:0]             rsp_status
);

   localparam int AW = tse_pkg::MEM_AW;
   localparam int SW = tse_pkg::SCAN_AW;

   // configuration registers
   logic [16:0] story_bytes_ff;
   logic [3:0]  story_version_ff;

   // scan registers
   logic [15:0]   key_ff;
   logic          words_ff;
   logic [6:0]    stride_ff;
   logic [SW-1:0] addr_ff;
   logic [15:0]   remain_ff;

   // compare-stage token
   logic        tok_vld_ff;
   logic        tok_err_ff;
   logic [15:0] tok_addr_ff;

   // result registers
   logic        rsp_valid_ff;
   logic [15:0] rsp_match_addr_ff;
   logic        rsp_matched_ff;
   logic [1:0]  rsp_status_ff;

   logic [7:0]    form_sel;
   logic [SW-1:0] limit;
   logic [SW-1:0] addr_last;
   logic [SW-1:0] addr_p1;
   logic          cur_oor;
   logic          wr_in_range;
   logic [7:0]    rd_hi;
   logic [7:0]    rd_lo;
   logic          hit;
   logic [15:0]   rsp_match_addr_in;
   logic [1:0]    rsp_status_in;

   // decode the form byte of the request
   assign form_sel = req_form_present ? req_form_byte : tse_pkg::FORM_DEFAULT;

   // clamp the story size to the physical memory
   assign limit = (story_bytes_ff < tse_pkg::MEM_LIMIT) ? story_bytes_ff
                                                        : tse_pkg::MEM_LIMIT;

   // range check on the last byte of the current entry
   assign addr_p1   = addr_ff + SW'(1);
   assign addr_last = words_ff ? addr_p1 : addr_ff;
   assign cur_oor   = (addr_last >= limit);

   // drop writes beyond the memory
   assign wr_in_range = ({1'b0, req_mem_addr} < tse_pkg::MEM_LIMIT);

   tse_ram #(
      .WIDTH (8),
      .DEPTH (tse_pkg::MEM_BYTES)
   ) u_story_ram (
      .clock     (clock),
      .wr_en     (ctl.write & wr_in_range),
      .wr_addr   (req_mem_addr[AW-1:0]),
      .wr_data   (req_mem_byte),
      .rd_addr_a (addr_ff[AW-1:0]),
      .rd_data_a (rd_hi),
      .rd_addr_b (addr_p1[AW-1:0]),
      .rd_data_b (rd_lo)
   );

   // compare the fetched entry with the key
   assign hit = words_ff ? ({rd_hi, rd_lo} == key_ff)
                         : ((key_ff[15:8] == 8'd0) && (rd_hi == key_ff[7:0]));

   // status toward the controller
   assign sts.ver_old     = (story_version_ff < tse_pkg::MIN_VERSION);
   assign sts.stride_zero = ((form_sel & tse_pkg::FORM_STRIDE) == 8'd0);
   assign sts.remain_zero = (remain_ff == 16'd0);
   assign sts.tok_vld     = tok_vld_ff;
   assign sts.tok_err     = tok_err_ff;
   assign sts.tok_hit     = hit;

   // build the result fields
   always_comb begin
      rsp_match_addr_in = 16'd0;
      rsp_status_in     = tse_pkg::ST_OK;
      case (ctl.kind)
         tse_pkg::RK_HIT:     rsp_match_addr_in = tok_addr_ff;
         tse_pkg::RK_VERSION: rsp_status_in     = tse_pkg::ST_VERSION;
         tse_pkg::RK_STRIDE:  rsp_status_in     = tse_pkg::ST_STRIDE;
         tse_pkg::RK_RANGE:   rsp_status_in     = tse_pkg::ST_RANGE;
         default:             rsp_status_in     = tse_pkg::ST_OK;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         story_bytes_ff   <= 17'd0;
         story_version_ff <= tse_pkg::VERSION_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tse_pkg::CSR_STORY_BYTES:   story_bytes_ff   <= csr_wdata;
            tse_pkg::CSR_STORY_VERSION: story_version_ff <= csr_wdata[3:0];
            default:                    story_bytes_ff   <= story_bytes_ff;
         endcase
      end
   end

   // load a scan, then advance one entry per issue
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff    <= req_search_key;
         words_ff  <= ((form_sel & tse_pkg::FORM_WORDS) != 8'd0);
         stride_ff <= form_sel[6:0];
         addr_ff   <= {1'b0, req_table_addr};
         remain_ff <= req_entry_count;
      end else if (ctl.issue) begin
         addr_ff   <= addr_ff + SW'(stride_ff);
         remain_ff <= remain_ff - 16'd1;
      end
      tok_err_ff  <= cur_oor;
      tok_addr_ff <= addr_ff[15:0];
   end

   // token valid and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tok_vld_ff   <= ctl.issue;
         rsp_valid_ff <= ctl.respond;
      end
   end

   // hold the result payload
   always_ff @(posedge clock) begin
      if (ctl.respond) begin
         rsp_match_addr_ff <= rsp_match_addr_in;
         rsp_matched_ff    <= (rsp_match_addr_in != 16'd0);
         rsp_status_ff     <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match_addr = rsp_match_addr_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

[rtl/core/tse_control.sv]
// ----------------------------------------------------------------------------
// tse_control: request sequencer for the table scan engine
// Accepts requests, runs the scan walk and picks the kind of each result.
// ----------------------------------------------------------------------------
module tse_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_func,
   input  tse_pkg::sts_type  sts,
   output tse_pkg::ctl_type  ctl,
   output logic              busy
);

   typedef enum logic [0:0] {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   // decode commands and next state
   always_comb begin
      state_in    = state_ff;
      ctl.write   = 1'b0;
      ctl.load    = 1'b0;
      ctl.issue   = 1'b0;
      ctl.respond = 1'b0;
      ctl.kind    = tse_pkg::RK_ACK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.respond = 1'b1;
               if (req_func == tse_pkg::FUNC_WRITE) begin
                  ctl.write = 1'b1;
                  ctl.kind  = tse_pkg::RK_ACK;
               end else if (sts.ver_old) begin
                  ctl.kind = tse_pkg::RK_VERSION;
               end else if (sts.stride_zero) begin
                  ctl.kind = tse_pkg::RK_STRIDE;
               end else begin
                  ctl.respond = 1'b0;
                  ctl.load    = 1'b1;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // the entry in the compare stage is older than the next issue
            if (sts.tok_vld && sts.tok_err) begin
               ctl.respond = 1'b1;
               ctl.kind    = tse_pkg::RK_RANGE;
               state_in    = S_IDLE;
            end else if (sts.tok_vld && sts.tok_hit) begin
               ctl.respond = 1'b1;
               ctl.kind    = tse_pkg::RK_HIT;
               state_in    = S_IDLE;
            end else if (sts.remain_zero) begin
               ctl.respond = 1'b1;
               ctl.kind    = tse_pkg::RK_MISS;
               state_in    = S_IDLE;
            end else begin
               ctl.issue = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

[rtl/core/table_scan_engine_core.sv]
// ----------------------------------------------------------------------------
// table_scan_engine_core: story memory with table scan
// Top level joining the request sequencer and the scan datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. req_func selects
//   a memory byte write or a table scan. Each request produces exactly one
//   result, shown for one cycle with rsp_valid high; the receiver cannot
//   stall it.
//   Writes and scans rejected for version or zero stride return their result
//   in the cycle after the request and never raise busy, so writes stream at
//   one per cycle.
//   A scan raises busy and walks one entry per cycle through the memory read
//   port and the key compare. It ends with a hit result at the first match,
//   a miss when the entry count runs out (also for an empty table), or a
//   range result for the first entry read past the story size. busy
//   drops in the cycle the result is shown.
//   Configuration (story size, version) goes through the csr_ channel, which
//   is always ready; write it only while no request is in flight.
//   Reset clears the sequencer and configuration (size 0, version 5); the
//   story memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module table_scan_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [15:0] req_mem_addr,
   input  logic [7:0]  req_mem_byte,
   input  logic [15:0] req_search_key,
   input  logic [15:0] req_table_addr,
   input  logic [15:0] req_entry_count,
   input  logic        req_form_present,
   input  logic [7:0]  req_form_byte,
   output logic        rsp_valid,
   output logic [15:0] rsp_match_addr,
   output logic        rsp_matched,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   tse_pkg::ctl_type ctl;
   tse_pkg::sts_type sts;

   // configuration is taken in any cycle
   assign csr_ready = 1'b1;

   tse_control u_control (
      .clock    (clock),
      .reset    (reset),
      .start    (start & ~busy),
      .req_func (req_func),
      .sts      (sts),
      .ctl      (ctl),
      .busy     (busy)
   );

   tse_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_mem_addr     (req_mem_addr),
      .req_mem_byte     (req_mem_byte),
      .req_search_key   (req_search_key),
      .req_table_addr   (req_table_addr),
      .req_entry_count  (req_entry_count),
      .req_form_present (req_form_present),
      .req_form_byte    (req_form_byte),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_match_addr   (rsp_match_addr),
      .rsp_matched      (rsp_matched),
      .rsp_status       (rsp_status)
   );

endmodule
